/* rtl/core/olir_pkg.sv */
// ============================================================================
// olir_pkg
// Shared types and constants for the ordered list insert/remove block.
// ============================================================================
`default_nettype none

package olir_pkg;

    // Storage geometry
    localparam int CAPACITY   = 8;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the command and response beats
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // Internal count and compare widths
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_AT   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // Per-cell update control
    typedef struct packed {
        logic load;   // take the new word
        logic up;     // take the lower neighbor's word
        logic down;   // take the upper neighbor's word
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/core/olir_cmd_if.sv */
// ============================================================================
// olir_cmd_if
// Command channel: valid/ready handshake with command, position and word.
// ============================================================================
`default_nettype none

interface olir_cmd_if
    import olir_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] entry_value;

    modport source (output valid, output command, output position,
                    output entry_value, input ready);
    modport sink   (input valid, input command, input position,
                    input entry_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/olir_rsp_if.sv */
// ============================================================================
// olir_rsp_if
// Response channel: valid/ready handshake with status, word and count.
// ============================================================================
`default_nettype none

interface olir_rsp_if
    import olir_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [COUNT_W-1:0]  count_after;

    modport source (output valid, output status, output removed_value,
                    output count_after, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input count_after, output ready);
endinterface

`default_nettype wire

/* rtl/core/olir_cell.sv */
// ============================================================================
// olir_cell
// One list slot: holds a word and loads the new word or a neighbor's word.
// ============================================================================
`default_nettype none

module olir_cell
    import olir_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_new,
    input  wire logic [DATA_WIDTH-1:0] i_lower,
    input  wire logic [DATA_WIDTH-1:0] i_upper,
    output      logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Next word select
    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_new;
        end else if (i_ctl.up) begin
            n_data = i_lower;
        end else if (i_ctl.down) begin
            n_data = i_upper;
        end
    end

    // Payload register, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/core/ordered_list_insert_remove_top.sv */
// ============================================================================
// ordered_list_insert_remove_top
// Fixed-capacity ordered list of words held in a row of shifting cells.
// ============================================================================
// Usage:
//   i_cmd (sink) takes one command beat: insert at head, tail or position,
//   or remove at head, tail or position. o_rsp (source) returns one beat
//   per command: status, removed word (zero unless a removal succeeds) and
//   the entry count after the command.
//   Latency: the response is valid the cycle after the command is accepted.
//   Throughput: one command per cycle while the receiver keeps up. All cells shift in parallel in the
//   accept cycle, so one beat through the cell row sets the rate; the
//   response register is the only stage.
//   A new command is taken whenever the response register is empty or is
//   being drained in the same cycle. While the receiver stalls, the pending
//   response holds and at most that one command is waiting on the output.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   response. Cell contents are not cleared; entries above the count are
//   never read.
// ============================================================================
`default_nettype none

module ordered_list_insert_remove_top
    import olir_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    olir_cmd_if.sink   i_cmd,
    olir_rsp_if.source o_rsp
);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [VALUE_W-1:0]    r_out_removed;
    logic [COUNT_W-1:0]    r_out_count;

    logic                  w_accept;
    logic                  w_is_ins;
    logic                  w_is_rem;
    logic                  w_ins_ok;
    logic                  w_rem_ok;
    logic [CMP_W-1:0]      w_cnt;
    logic [CMP_W-1:0]      w_pos;
    logic [STATUS_W-1:0]   w_status;
    logic [DATA_WIDTH-1:0] w_new;
    logic [DATA_WIDTH-1:0] w_taken;

    t_cell_ctl             w_ctl  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_hit  [CAPACITY];

    // Handshake
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_cnt = CMP_W'(r_count);
    assign w_new = DATA_WIDTH'(i_cmd.entry_value);

    // Command decode: target position and kind
    always_comb begin
        w_is_ins = 1'b0;
        w_is_rem = 1'b0;
        w_pos    = '0;
        unique case (i_cmd.command)
            CMD_INS_HEAD: begin
                w_is_ins = 1'b1;
            end
            CMD_INS_TAIL: begin
                w_is_ins = 1'b1;
                w_pos    = w_cnt;
            end
            CMD_INS_AT: begin
                w_is_ins = 1'b1;
                w_pos    = CMP_W'(i_cmd.position);
            end
            CMD_REM_HEAD: begin
                w_is_rem = 1'b1;
            end
            CMD_REM_TAIL: begin
                w_is_rem = 1'b1;
                w_pos    = (w_cnt == '0) ? '0 : w_cnt - CMP_W'(1);
            end
            CMD_REM_AT: begin
                w_is_rem = 1'b1;
                w_pos    = CMP_W'(i_cmd.position);
            end
            default: begin
            end
        endcase
    end

    // Status: capacity/empty checks come before the position check
    always_comb begin
        w_status = ST_BADPOS;
        if (w_is_ins) begin
            if (w_cnt >= CMP_W'(CAPACITY)) begin
                w_status = ST_FULL;
            end else if (w_pos > w_cnt) begin
                w_status = ST_BADPOS;
            end else begin
                w_status = ST_OK;
            end
        end else if (w_is_rem) begin
            if (w_cnt == '0) begin
                w_status = ST_EMPTY;
            end else if (w_pos >= w_cnt) begin
                w_status = ST_BADPOS;
            end else begin
                w_status = ST_OK;
            end
        end
    end

    assign w_ins_ok = w_accept && w_is_ins && (w_status == ST_OK);
    assign w_rem_ok = w_accept && w_is_rem && (w_status == ST_OK);

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_lower;
        logic [DATA_WIDTH-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = w_new;
        end else begin : g_mid_lo
            assign w_lower = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_data[g+1];
        end

        assign w_ctl[g].load = w_ins_ok && (CMP_W'(g) == w_pos);
        assign w_ctl[g].up   = w_ins_ok && (CMP_W'(g) >  w_pos);
        assign w_ctl[g].down = w_rem_ok && (CMP_W'(g) >= w_pos);

        // Word at the removal point, zero elsewhere
        assign w_hit[g] = (CMP_W'(g) == w_pos) ? w_data[g] : '0;

        olir_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_new   (w_new),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[g])
        );
    end

    // OR of the one-hot selected cell words
    always_comb begin
        w_taken = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_taken = w_taken | w_hit[k];
        end
    end

    // Count update
    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rem_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status  <= w_status;
            r_out_removed <= w_rem_ok ? VALUE_W'(w_taken) : '0;
            r_out_count   <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.removed_value = r_out_removed;
    assign o_rsp.count_after   = r_out_count;

    // Assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_count == COUNT_W'(r_count)))
        else $error("response count differs from list count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_removed == '0))
        else $error("failed command reports a removed word");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (r_out_valid && !o_rsp.ready))
        else $error("command side stalled without pending response");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("count changed without a command");

endmodule

`default_nettype wire

/* tb/tb_ordered_list_insert_remove_top.sv */
// ============================================================================
// tb_ordered_list_insert_remove_top
// Self-checking bench for the ordered list insert/remove block. Commands go
// in through the command channel with random gaps, and responses are drained
// with random stalls. Each accepted command runs through a local list
// predictor, and every response is checked field by field. A directed pass
// covers empty, full, boundary positions and unknown commands. Random phases
// then move the list between empty and full.
// ============================================================================
`default_nettype none

module tb_ordered_list_insert_remove_top;
    import olir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed_value;
        logic [COUNT_W-1:0]  count_after;
    } t_list_reply;

    // ------------------------------------------------------------------------
    // List predictor and response checker
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [DATA_WIDTH-1:0] cells [CAPACITY];
        int unsigned           held;
        t_list_reply           awaiting [$];
        int                    errors;
        int                    checked;
        int                    status_seen [4];

        function new();
            held    = 0;
            errors  = 0;
            checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int outstanding();
            return awaiting.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Full check comes before the position check
        function logic [STATUS_W-1:0] insert_word(int unsigned at,
                                                 logic [VALUE_W-1:0] word);
            if (held >= CAPACITY) return ST_FULL;
            if (at > held) return ST_BADPOS;
            for (int unsigned i = held; i > at; i--) cells[i] = cells[i-1];
            cells[at] = word[DATA_WIDTH-1:0];
            held++;
            return ST_OK;
        endfunction

        // Empty check comes before the position check
        function logic [STATUS_W-1:0] remove_word(int unsigned at,
                                                 output logic [VALUE_W-1:0] taken);
            taken = '0;
            if (held == 0) return ST_EMPTY;
            if (at >= held) return ST_BADPOS;
            taken = VALUE_W'(cells[at]);
            for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i+1];
            held--;
            return ST_OK;
        endfunction

        // Called at the edge where a command beat is taken
        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] word);
            t_list_reply r;
            r.removed_value = '0;
            case (cmd)
                CMD_INS_HEAD: r.status = insert_word(0, word);
                CMD_INS_TAIL: r.status = insert_word(held, word);
                CMD_INS_AT:   r.status = insert_word(pos, word);
                CMD_REM_HEAD: r.status = remove_word(0, r.removed_value);
                CMD_REM_TAIL: r.status = remove_word((held == 0) ? 0 : held - 1,
                                                     r.removed_value);
                CMD_REM_AT:   r.status = remove_word(pos, r.removed_value);
                default:      r.status = ST_BADPOS;
            endcase
            r.count_after = held[COUNT_W-1:0];
            awaiting.push_back(r);
        endfunction

        // Called at the edge where a response beat is taken
        task check_response(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] removed,
                            logic [COUNT_W-1:0] count);
            t_list_reply exp;
            if (awaiting.size() == 0) begin
                report_mismatch($sformatf("response with nothing outstanding (st %0d)",
                                          status));
                return;
            end
            exp = awaiting.pop_front();
            checked++;
            status_seen[exp.status]++;
            if (status !== exp.status)
                report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                          checked, status, exp.status));
            if (removed !== exp.removed_value)
                report_mismatch($sformatf("reply %0d removed %08h, want %08h",
                                          checked, removed, exp.removed_value));
            if (count !== exp.count_after)
                report_mismatch($sformatf("reply %0d count %0d, want %0d",
                                          checked, count, exp.count_after));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, interfaces, block under test
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #10 i_clk = ~i_clk;

    olir_cmd_if cmd_if ();
    olir_rsp_if rsp_if ();

    ordered_list_insert_remove_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    list_scoreboard list_sb = new();

    // Per-side switches for gap-free stretches
    bit cmd_steady = 1'b0;
    bit rsp_steady = 1'b0;
    int phases_run = 0;

    // ------------------------------------------------------------------------
    // Command driver: valid stays high across back-to-back beats
    // ------------------------------------------------------------------------
    task send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                      logic [VALUE_W-1:0] word);
        int gap;
        gap = cmd_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= cmd;
        cmd_if.position    <= pos;
        cmd_if.entry_value <= word;
        do @(posedge i_clk); while (!cmd_if.ready);
        list_sb.note_command(cmd, pos, word);
    endtask

    // Hold off the sender until every reply is back
    task wait_for_results();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (list_sb.outstanding() != 0);
    endtask

    function logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Random phase; ins_pct sets the insert share, which drives the fill level
    task run_phase(int n, int ins_pct, bit tx_steady, bit rx_steady);
        int                 r;
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   pos;
        cmd_steady = tx_steady;
        rsp_steady = rx_steady;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
            else if (r < 3 + ins_pct)
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_INS_HEAD;
                    1:       cmd = CMD_INS_TAIL;
                    default: cmd = CMD_INS_AT;
                endcase
            else
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_REM_HEAD;
                    1:       cmd = CMD_REM_TAIL;
                    default: cmd = CMD_REM_AT;
                endcase
            // mostly positions around the current fill, some anywhere
            if ($urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, list_sb.held));
            else
                pos = POS_W'($urandom_range(0, 15));
            send_command(cmd, pos, pick_word());
        end
        wait_for_results();
        phases_run++;
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stalls between beats
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rsp_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            list_sb.check_response(rsp_if.status, rsp_if.removed_value,
                                   rsp_if.count_after);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.command     <= CMD_INS_HEAD;
        cmd_if.position    <= '0;
        cmd_if.entry_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: empty status wins over a bad position
        send_command(CMD_REM_HEAD, '0, '0);
        send_command(CMD_REM_TAIL, '0, '0);
        send_command(CMD_REM_AT, '0, 32'h1234_5678);
        send_command(CMD_REM_AT, POS_MAX, '0);
        // Insert-at beyond count, then at count (append)
        send_command(CMD_INS_AT, 4'd1, 32'hDEAD_BEEF);
        send_command(CMD_INS_AT, '0, '0);
        send_command(CMD_INS_TAIL, '0, '1);
        send_command(CMD_INS_HEAD, POS_MAX, 32'hA5A5_A5A5);
        send_command(CMD_INS_AT, POS_MAX, 32'h5A5A_5A5A);
        send_command(CMD_INS_AT, 4'd3, 32'h8000_0001);
        send_command(CMD_INS_AT, 4'd1, 32'h7FFF_FFFE);
        send_command(CMD_INS_HEAD, '0, 32'h0F0F_0F0F);
        send_command(CMD_INS_TAIL, '0, 32'hF0F0_F0F0);
        send_command(CMD_INS_AT, 4'd4, 32'h5555_5555);
        // Full list: full status wins over a bad position
        send_command(CMD_INS_TAIL, '0, 32'hCAFE_0000);
        send_command(CMD_INS_AT, POS_MAX, 32'hCAFE_0001);
        send_command(CMD_INS_HEAD, '0, 32'hCAFE_0002);
        // Unknown commands
        send_command(CMD_RSVD_A, 4'd2, '1);
        send_command(CMD_RSVD_B, POS_MAX, '1);
        // Remove-at at and past the count, then real removals
        send_command(CMD_REM_AT, 4'd8, '0);
        send_command(CMD_REM_AT, POS_MAX, '0);
        send_command(CMD_REM_AT, 4'd3, '0);
        send_command(CMD_REM_AT, 4'd6, '0);
        send_command(CMD_REM_TAIL, '0, '0);
        send_command(CMD_REM_HEAD, '0, '0);
        wait_for_results();

        // Random phases: balanced, fill-heavy, drain-heavy, balanced
        run_phase(100, 48, 1'b1, 1'b1);
        run_phase(100, 70, 1'b0, 1'b0);
        run_phase(100, 28, 1'b0, 1'b1);
        run_phase(100, 48, 1'b0, 1'b0);

        // Catch any stray reply
        repeat (6) @(posedge i_clk);

        $display("covered %0d replies over directed and %0d random phases",
                 list_sb.checked, phases_run);
        $display("statuses seen: ok %0d, full %0d, empty %0d, bad position %0d",
                 list_sb.status_seen[ST_OK], list_sb.status_seen[ST_FULL],
                 list_sb.status_seen[ST_EMPTY], list_sb.status_seen[ST_BADPOS]);
        if (list_sb.errors == 0 && list_sb.outstanding() == 0)
            $display("tb_ordered_list_insert_remove_top: clean");
        else
            $display("tb_ordered_list_insert_remove_top: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("timeout waiting on the block");
        $display("tb_ordered_list_insert_remove_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
